// File: rtl/vmso_pkg.sv
// Shared types and constants for the square-mark luma overlay.
`default_nettype none

package vmso_pkg;

   // Field widths of the pixel stream
   localparam int LumaWidth   = 8;
   localparam int ColumnWidth = 12;
   localparam int LinesWidth  = 12;

   // Register widths
   localparam int DimWidth       = 12;
   localparam int DataCountWidth = 7;
   localparam int DataBitsWidth  = 64;
   localparam int DataIdxWidth   = $clog2(DataBitsWidth);
   localparam int CsrIndexWidth  = 3;
   localparam int CsrDataWidth   = 64;

   // Square index covers markers plus data squares
   localparam int SquareIdxWidth = DimWidth + 1;

   // One divider step per quotient bit
   localparam int DivSteps = ColumnWidth;

   localparam logic [LumaWidth-1:0] LumaWhite = {LumaWidth{1'b1}};
   localparam logic [LumaWidth-1:0] LumaBlack = '0;

   localparam logic [DataCountWidth-1:0] DataCountMax = DataCountWidth'(DataBitsWidth);

   // Register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SQUARE_WIDTH  = 3'd0,
      CSR_SQUARE_HEIGHT = 3'd1,
      CSR_MARKER_COUNT  = 3'd2,
      CSR_DATA_COUNT    = 3'd3,
      CSR_DATA_BITS     = 3'd4,
      CSR_ENABLED       = 3'd5,
      CSR_FIRST_COLUMN  = 3'd6,
      CSR_BOTTOM_GAP    = 3'd7
   } csr_index_type;

   // Register file contents
   typedef struct packed {
      logic [DimWidth-1:0]       square_width;
      logic [DimWidth-1:0]       square_height;
      logic [DimWidth-1:0]       marker_count;
      logic [DataCountWidth-1:0] data_count;
      logic [DataBitsWidth-1:0]  data_bits;
      logic                      enabled;
      logic [DimWidth-1:0]       first_column;
      logic [DimWidth-1:0]       bottom_gap;
   } cfg_type;

   // Word carried down the divider pipeline
   typedef struct packed {
      logic [LumaWidth-1:0]   luma;
      logic                   hit;
      logic [ColumnWidth-1:0] dividend;
      logic [ColumnWidth-1:0] quotient;
      logic [DimWidth-1:0]    remainder;
   } div_word_type;

endpackage

`default_nettype wire

// File: rtl/vmso_csr.sv
// Configuration register file for the square-mark overlay.
`default_nettype none

module vmso_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [vmso_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [vmso_pkg::CsrDataWidth-1:0]  csr_data,
   output vmso_pkg::cfg_type                       cfg
);
   import vmso_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Writes are always taken
   assign csr_ready = 1'b1;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_SQUARE_WIDTH:  cfg_in.square_width  = csr_data[DimWidth-1:0];
            CSR_SQUARE_HEIGHT: cfg_in.square_height = csr_data[DimWidth-1:0];
            CSR_MARKER_COUNT:  cfg_in.marker_count  = csr_data[DimWidth-1:0];
            CSR_DATA_COUNT:    cfg_in.data_count    = csr_data[DataCountWidth-1:0];
            CSR_DATA_BITS:     cfg_in.data_bits     = csr_data[DataBitsWidth-1:0];
            CSR_ENABLED:       cfg_in.enabled       = csr_data[0];
            CSR_FIRST_COLUMN:  cfg_in.first_column  = csr_data[DimWidth-1:0];
            CSR_BOTTOM_GAP:    cfg_in.bottom_gap    = csr_data[DimWidth-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.square_width  <= DimWidth'(4);
         cfg_ff.square_height <= DimWidth'(16);
         cfg_ff.marker_count  <= DimWidth'(4);
         cfg_ff.data_count    <= DataCountWidth'(5);
         cfg_ff.data_bits     <= DataBitsWidth'(10);
         cfg_ff.enabled       <= 1'b1;
         cfg_ff.first_column  <= '0;
         cfg_ff.bottom_gap    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: rtl/vmso_front.sv
// Input register: band window test and column offset for each pixel word.
`default_nettype none

module vmso_front (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire vmso_pkg::cfg_type                cfg,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic [vmso_pkg::LumaWidth-1:0]   req_luma_in,
   input  wire logic [vmso_pkg::ColumnWidth-1:0] req_column,
   input  wire logic [vmso_pkg::LinesWidth-1:0]  req_lines_below,
   output logic                                  out_valid,
   input  wire logic                             out_ready,
   output vmso_pkg::div_word_type                out_word
);
   import vmso_pkg::*;

   logic                 valid_ff;
   logic                 valid_in;
   div_word_type         word_ff;
   div_word_type         word_in;
   logic                 take;
   logic [LinesWidth:0]  band_top;
   logic                 vert_hit;
   logic                 horz_hit;

   // Register frees up when empty or when downstream takes it
   assign take      = req_valid && (!valid_ff || out_ready);
   assign req_stall = valid_ff && !out_ready;

   // Band window: lines and columns
   always_comb begin
      band_top = {1'b0, cfg.bottom_gap} + {1'b0, cfg.square_height};
      vert_hit = (req_lines_below >= cfg.bottom_gap) &&
                 ({1'b0, req_lines_below} < band_top);
      horz_hit = (req_column >= cfg.first_column);

      word_in.luma      = req_luma_in;
      word_in.hit       = cfg.enabled && (cfg.square_width != '0) &&
                          (cfg.square_height != '0) && vert_hit && horz_hit;
      word_in.dividend  = req_column - cfg.first_column;
      word_in.quotient  = '0;
      word_in.remainder = '0;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

`default_nettype wire

// File: rtl/vmso_div.sv
// Pipelined restoring divider: column offset over square width, one bit per stage.
`default_nettype none

module vmso_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [vmso_pkg::DimWidth-1:0] square_width,
   input  wire logic                          in_valid,
   output logic                               in_ready,
   input  wire vmso_pkg::div_word_type        in_word,
   output logic                               out_valid,
   input  wire logic                          out_ready,
   output vmso_pkg::div_word_type             out_word
);
   import vmso_pkg::*;

   // One quotient bit: shift in the next dividend bit, subtract if it fits
   function automatic div_word_type div_step(div_word_type w,
                                             logic [DimWidth-1:0] divisor);
      div_word_type     r;
      logic [DimWidth:0] shifted;
      logic              fits;
      r       = w;
      shifted = {w.remainder, w.dividend[ColumnWidth-1]};
      fits    = (shifted >= {1'b0, divisor});
      if (fits) begin
         shifted = shifted - {1'b0, divisor};
      end
      r.remainder = shifted[DimWidth-1:0];
      r.dividend  = {w.dividend[ColumnWidth-2:0], 1'b0};
      r.quotient  = {w.quotient[ColumnWidth-2:0], fits};
      return r;
   endfunction

   logic [DivSteps-1:0] valid_ff;
   logic [DivSteps-1:0] valid_in;
   div_word_type        word_ff [DivSteps];
   div_word_type        word_in [DivSteps];
   logic [DivSteps:0]   ready;
   logic [DivSteps-1:0] src_valid;
   div_word_type        src_word [DivSteps];

   assign ready[DivSteps] = out_ready;
   assign in_ready        = ready[0];

   for (genvar i = 0; i < DivSteps; i++) begin : g_stage
      // Stage source: front word or previous stage
      if (i == 0) begin : g_first
         assign src_valid[i] = in_valid;
         assign src_word[i]  = in_word;
      end else begin : g_next
         assign src_valid[i] = valid_ff[i-1];
         assign src_word[i]  = word_ff[i-1];
      end

      // Stage can load when empty or when its contents move on
      assign ready[i] = !valid_ff[i] || ready[i+1];

      always_comb begin
         valid_in[i] = ready[i] ? src_valid[i] : valid_ff[i];
         word_in[i]  = div_step(src_word[i], square_width);
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else begin
            valid_ff[i] <= valid_in[i];
         end
      end

      always_ff @(posedge clock) begin
         if (ready[i] && src_valid[i]) begin
            word_ff[i] <= word_in[i];
         end
      end
   end

   assign out_valid = valid_ff[DivSteps-1];
   assign out_word  = word_ff[DivSteps-1];

endmodule

`default_nettype wire

// File: rtl/vmso_paint.sv
// Square color pick and result register.
`default_nettype none

module vmso_paint (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire vmso_pkg::cfg_type              cfg,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire vmso_pkg::div_word_type         in_word,
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [vmso_pkg::LumaWidth-1:0]      rsp_luma_out
);
   import vmso_pkg::*;

   logic                      valid_ff;
   logic                      valid_in;
   logic [LumaWidth-1:0]      luma_ff;
   logic [LumaWidth-1:0]      luma_in;
   logic                      take;
   logic [DataCountWidth-1:0] dc_sat;
   logic [SquareIdxWidth-1:0] total;
   logic [SquareIdxWidth-1:0] k_ext;
   logic [SquareIdxWidth-1:0] bit_pos;
   logic [DataIdxWidth-1:0]   bit_idx;
   logic                      in_band;
   logic                      is_marker;
   logic [LumaWidth-1:0]      pix;

   assign in_ready = !valid_ff || !rsp_stall;
   assign take     = in_valid && in_ready;

   // Pick the square color: markers alternate, data squares show bits MSB first
   always_comb begin
      dc_sat    = (cfg.data_count > DataCountMax) ? DataCountMax : cfg.data_count;
      total     = {1'b0, cfg.marker_count} + SquareIdxWidth'(dc_sat);
      k_ext     = {1'b0, in_word.quotient};
      in_band   = in_word.hit && (k_ext < total);
      is_marker = (k_ext < {1'b0, cfg.marker_count});
      bit_pos   = total - SquareIdxWidth'(1) - k_ext;
      bit_idx   = bit_pos[DataIdxWidth-1:0];
      if (is_marker) begin
         pix = in_word.quotient[0] ? LumaWhite : LumaBlack;
      end else begin
         pix = cfg.data_bits[bit_idx] ? LumaWhite : LumaBlack;
      end
      luma_in = in_band ? pix : in_word.luma;
   end

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         luma_ff <= luma_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_luma_out = luma_ff;

endmodule

`default_nettype wire

// File: rtl/video_mark_square_overlay.sv
// Square-mark overlay on a raster luma stream: top level.
//
// Pixel words enter on the req_ channel (luma, column, lines below) and leave
// on the rsp_ channel, one result word per pixel word, in order. Pixels inside
// the mark band are replaced by 0 or 255; all others pass unchanged.
// Both channels use valid/stall: a word moves at a clock edge where valid is
// high and stall is low.
// Path: input register, 12-stage divider pipeline for column offset over
// square width (one quotient bit per stage), result register.
// Throughput is one word per cycle while the receiver does not stall.
// When the receiver stalls, words keep entering until all 14 registers hold
// one, then req_stall rises; empty stages are filled meanwhile.
// Registers are written through csr_ (index, data, valid/ready; ready is
// always high); the user must write them only while no pixel word is in
// flight, which the block itself does not enforce.
// Synchronous reset empties the pipeline and loads the register defaults:
// width 4, height 16, 4 markers, 5 data squares, data 10, enabled, offsets 0.
`default_nettype none

module video_mark_square_overlay (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // Pixel input
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [vmso_pkg::LumaWidth-1:0]     req_luma_in,
   input  wire logic [vmso_pkg::ColumnWidth-1:0]   req_column,
   input  wire logic [vmso_pkg::LinesWidth-1:0]    req_lines_below,
   // Pixel output
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic [vmso_pkg::LumaWidth-1:0]          rsp_luma_out,
   // Register writes
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [vmso_pkg::CsrIndexWidth-1:0] csr_index,
   input  wire logic [vmso_pkg::CsrDataWidth-1:0]  csr_data
);
   import vmso_pkg::*;

   cfg_type      cfg;
   logic         front_valid;
   logic         front_ready;
   div_word_type front_word;
   logic         div_valid;
   logic         div_ready;
   div_word_type div_word;

   // Register file
   vmso_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // Band test and input register
   vmso_front u_front (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma_in     (req_luma_in),
      .req_column      (req_column),
      .req_lines_below (req_lines_below),
      .out_valid       (front_valid),
      .out_ready       (front_ready),
      .out_word        (front_word)
   );

   // Square index from column offset
   vmso_div u_div (
      .clock        (clock),
      .reset        (reset),
      .square_width (cfg.square_width),
      .in_valid     (front_valid),
      .in_ready     (front_ready),
      .in_word      (front_word),
      .out_valid    (div_valid),
      .out_ready    (div_ready),
      .out_word     (div_word)
   );

   // Color pick and result register
   vmso_paint u_paint (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .in_valid     (div_valid),
      .in_ready     (div_ready),
      .in_word      (div_word),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_luma_out (rsp_luma_out)
   );

endmodule

`default_nettype wire

// File: sim/video_mark_square_overlay_tb.sv
// Self-checking testbench for the square-mark luma overlay: directed table, random phases.
`default_nettype none

module video_mark_square_overlay_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import vmso_pkg::*;

   localparam int ClockPeriod    = 12;
   localparam int ResetCycles    = 5;
   localparam int IdlePercent    = 38;
   localparam int HoldCycles     = 300;
   localparam int DrainCycles    = 30;
   localparam int WatchdogLimit  = 4000;
   localparam int RandomPhases   = 19;
   localparam int PixelsPerPhase = 100;
   localparam int PressurePhase  = 3;
   localparam int QuietPhase     = 7;
   localparam int MaxCoord       = 4095;

   typedef enum logic {ROW_CSR, ROW_PIXEL} row_kind_type;

   // One row of the directed table: a register write or a pixel word
   typedef struct {
      row_kind_type           kind;
      csr_index_type          index;
      logic [CsrDataWidth-1:0] value;
      logic [LumaWidth-1:0]   luma;
      logic [ColumnWidth-1:0] column;
      logic [LinesWidth-1:0]  below;
      bit                     known;
      logic [LumaWidth-1:0]   luma_out;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [LumaWidth-1:0]     req_luma_in = '0;
   logic [ColumnWidth-1:0]   req_column = '0;
   logic [LinesWidth-1:0]    req_lines_below = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [LumaWidth-1:0]     rsp_luma_out;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index = '0;
   logic [CsrDataWidth-1:0]  csr_data = '0;

   // Predictor copy of the registers and of the square tracking state
   cfg_type                  mark_cfg;
   logic [SquareIdxWidth-1:0] square_idx;
   logic [DimWidth-1:0]      square_pos;

   logic [LumaWidth-1:0]     luma_expect_q[$];
   stim_row_type             directed_rows[$];
   int                       mismatch_count = 0;
   int                       idle_cycles = 0;
   bit                       hold_request = 1'b0;
   bit                       hold_done = 1'b0;
   bit                       sender_quiet = 1'b0;
   bit                       receiver_quiet = 1'b0;

   video_mark_square_overlay DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_luma_in     (req_luma_in),
      .req_column      (req_column),
      .req_lines_below (req_lines_below),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_luma_out    (rsp_luma_out),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #(ClockPeriod / 2) clock = ~clock;
   end

   // Overlay predictor: band test, square lookup, marker or data color
   function automatic logic [LumaWidth-1:0] overlay_luma(input logic [LumaWidth-1:0] luma,
                                                         input logic [ColumnWidth-1:0] col,
                                                         input logic [LinesWidth-1:0] below);
      int unsigned          dc;
      int unsigned          total;
      int unsigned          band_top;
      int unsigned          rel;
      int unsigned          k;
      int unsigned          pos;
      int unsigned          bit_sel;
      bit                   in_band;
      logic [LumaWidth-1:0] res;
      dc = (mark_cfg.data_count > DataCountMax) ? 64 : int'(mark_cfg.data_count);
      total = int'(mark_cfg.marker_count) + dc;
      band_top = int'(mark_cfg.bottom_gap) + int'(mark_cfg.square_height);
      res = luma;
      in_band = 1'b0;
      k = 0;
      pos = 0;
      if (mark_cfg.enabled && mark_cfg.square_width != '0 && mark_cfg.square_height != '0 &&
          below >= mark_cfg.bottom_gap && int'(below) < band_top &&
          col >= mark_cfg.first_column) begin
         rel = int'(col) - int'(mark_cfg.first_column);
         k = rel / int'(mark_cfg.square_width);
         pos = rel % int'(mark_cfg.square_width);
         in_band = (k < total);
      end
      if (in_band) begin
         if (k < int'(mark_cfg.marker_count)) begin
            res = k[0] ? LumaWhite : LumaBlack;
         end else begin
            // data squares run from the top used bit down to bit 0
            bit_sel = dc - 1 - (k - int'(mark_cfg.marker_count));
            res = mark_cfg.data_bits[bit_sel[5:0]] ? LumaWhite : LumaBlack;
         end
         square_idx = k[SquareIdxWidth-1:0];
         square_pos = pos[DimWidth-1:0];
      end else begin
         square_idx = '0;
         square_pos = '0;
      end
      return res;
   endfunction

   function automatic stim_row_type csr_row(input csr_index_type idx,
                                            input logic [CsrDataWidth-1:0] val);
      stim_row_type r;
      r.kind = ROW_CSR;
      r.index = idx;
      r.value = val;
      r.luma = '0;
      r.column = '0;
      r.below = '0;
      r.known = 1'b0;
      r.luma_out = '0;
      return r;
   endfunction

   function automatic stim_row_type pix_row(input logic [LumaWidth-1:0] luma,
                                            input logic [ColumnWidth-1:0] col,
                                            input logic [LinesWidth-1:0] below,
                                            input bit known,
                                            input logic [LumaWidth-1:0] luma_out);
      stim_row_type r;
      r.kind = ROW_PIXEL;
      r.index = CSR_SQUARE_WIDTH;
      r.value = '0;
      r.luma = luma;
      r.column = col;
      r.below = below;
      r.known = known;
      r.luma_out = luma_out;
      return r;
   endfunction

   // Typical value most of the time, one of the two extremes now and then
   function automatic int unsigned pick(input int unsigned lo, input int unsigned hi,
                                        input int unsigned rare_low, input int unsigned rare_high);
      case ($urandom_range(9))
         0: begin
            return rare_low;
         end
         1: begin
            return rare_high;
         end
         default: begin
            return $urandom_range(hi, lo);
         end
      endcase
   endfunction

   // Random junk above the register's width, which the block must drop
   function automatic logic [CsrDataWidth-1:0] with_noise(input int unsigned v, input int w);
      logic [CsrDataWidth-1:0] junk;
      junk = {$urandom(), $urandom()};
      return (junk << w) | 64'(v);
   endfunction

   function automatic int clamp_coord(input int v);
      if (v < 0) begin
         return 0;
      end
      if (v > MaxCoord) begin
         return MaxCoord;
      end
      return v;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [CsrDataWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_SQUARE_WIDTH: begin
            mark_cfg.square_width = val[DimWidth-1:0];
         end
         CSR_SQUARE_HEIGHT: begin
            mark_cfg.square_height = val[DimWidth-1:0];
         end
         CSR_MARKER_COUNT: begin
            mark_cfg.marker_count = val[DimWidth-1:0];
         end
         CSR_DATA_COUNT: begin
            mark_cfg.data_count = val[DataCountWidth-1:0];
         end
         CSR_DATA_BITS: begin
            mark_cfg.data_bits = val;
         end
         CSR_ENABLED: begin
            mark_cfg.enabled = val[0];
         end
         CSR_FIRST_COLUMN: begin
            mark_cfg.first_column = val[DimWidth-1:0];
         end
         CSR_BOTTOM_GAP: begin
            mark_cfg.bottom_gap = val[DimWidth-1:0];
         end
         default: begin
         end
      endcase
   endtask

   // Offer one pixel word, maybe after a gap; predict at acceptance
   task automatic send_pixel(input logic [LumaWidth-1:0] luma,
                             input logic [ColumnWidth-1:0] col,
                             input logic [LinesWidth-1:0] below,
                             input bit use_typed,
                             input logic [LumaWidth-1:0] typed_luma);
      logic [LumaWidth-1:0] predicted;
      // each cycle idles with the same odds, so gaps fill the right share
      if (!sender_quiet) begin
         while ($urandom_range(99) < IdlePercent) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_luma_in <= luma;
      req_column <= col;
      req_lines_below <= below;
      do @(posedge clock); while (req_stall);
      predicted = overlay_luma(luma, col, below);
      luma_expect_q.push_back(use_typed ? typed_luma : predicted);
   endtask

   // Let every word in flight come out, then wait out the drain period
   task automatic wait_idle();
      while (luma_expect_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   // Stimulus: directed table, then random phases
   initial begin
      bit          in_csr;
      int          total;
      int          span;
      int          run_left;
      int          run_col;
      int          run_below;
      int          col;
      int          below;
      logic [CsrDataWidth-1:0] bits_word;

      mark_cfg = '{square_width: 12'd4, square_height: 12'd16, marker_count: 12'd4,
                   data_count: 7'd5, data_bits: 64'd10, enabled: 1'b1,
                   first_column: 12'd0, bottom_gap: 12'd0};
      square_idx = '0;
      square_pos = '0;

      directed_rows = '{
         // reset settings: markers on columns 0..15, data 01010 on 16..35, lines 0..15
         pix_row(8'h5A, 12'd0, 12'd0, 1'b1, LumaBlack),
         pix_row(8'h00, 12'd4, 12'd0, 1'b1, LumaWhite),
         pix_row(8'hFF, 12'd16, 12'd15, 1'b1, LumaBlack),
         pix_row(8'h00, 12'd20, 12'd15, 1'b1, LumaWhite),
         pix_row(8'hFF, 12'd35, 12'd0, 1'b1, LumaBlack),
         pix_row(8'hC3, 12'd36, 12'd0, 1'b1, 8'hC3),
         pix_row(8'h81, 12'd0, 12'd16, 1'b1, 8'h81),
         pix_row(8'hFF, 12'd4095, 12'd4095, 1'b1, 8'hFF),
         pix_row(8'h3C, 12'd27, 12'd9, 1'b0, 8'h00),
         // disabled passes everything
         csr_row(CSR_ENABLED, 64'd0),
         pix_row(8'h12, 12'd4, 12'd0, 1'b1, 8'h12),
         // zero width, then zero height: empty band
         csr_row(CSR_ENABLED, 64'd1),
         csr_row(CSR_SQUARE_WIDTH, 64'd0),
         pix_row(8'h34, 12'd4, 12'd0, 1'b1, 8'h34),
         csr_row(CSR_SQUARE_WIDTH, 64'd1),
         csr_row(CSR_SQUARE_HEIGHT, 64'd0),
         pix_row(8'h56, 12'd0, 12'd0, 1'b1, 8'h56),
         // no markers, data count saturated to 64 one-column squares
         csr_row(CSR_SQUARE_HEIGHT, 64'd4095),
         csr_row(CSR_MARKER_COUNT, 64'd0),
         csr_row(CSR_DATA_COUNT, 64'd127),
         csr_row(CSR_DATA_BITS, 64'h8000_0000_0000_0001),
         pix_row(8'h00, 12'd0, 12'd0, 1'b1, LumaWhite),
         pix_row(8'h00, 12'd63, 12'd0, 1'b1, LumaWhite),
         pix_row(8'hFF, 12'd1, 12'd0, 1'b1, LumaBlack),
         pix_row(8'h77, 12'd64, 12'd0, 1'b1, 8'h77),
         pix_row(8'h00, 12'd0, 12'd4094, 1'b1, LumaWhite),
         pix_row(8'h99, 12'd0, 12'd4095, 1'b1, 8'h99),
         pix_row(8'h00, 12'd40, 12'd300, 1'b0, 8'h00),
         // markers only, pushed into the far corner
         csr_row(CSR_MARKER_COUNT, 64'd4095),
         csr_row(CSR_DATA_COUNT, 64'd0),
         csr_row(CSR_FIRST_COLUMN, 64'd4095),
         csr_row(CSR_BOTTOM_GAP, 64'd4095),
         pix_row(8'hAA, 12'd4095, 12'd4095, 1'b1, LumaBlack),
         pix_row(8'hAA, 12'd4094, 12'd4095, 1'b1, 8'hAA),
         pix_row(8'hAA, 12'd4095, 12'd4094, 1'b1, 8'hAA),
         // widest square
         csr_row(CSR_FIRST_COLUMN, 64'd0),
         csr_row(CSR_BOTTOM_GAP, 64'd0),
         csr_row(CSR_SQUARE_WIDTH, 64'd4095),
         pix_row(8'h00, 12'd4095, 12'd0, 1'b1, LumaWhite),
         pix_row(8'hFF, 12'd4094, 12'd0, 1'b1, LumaBlack)
      };

      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table walk
      in_csr = 1'b0;
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CSR) begin
            if (!in_csr) begin
               req_valid <= 1'b0;
               wait_idle();
            end
            write_reg(directed_rows[i].index, directed_rows[i].value);
            in_csr = 1'b1;
         end else begin
            if (in_csr) begin
               csr_valid <= 1'b0;
            end
            in_csr = 1'b0;
            send_pixel(directed_rows[i].luma, directed_rows[i].column, directed_rows[i].below,
                       directed_rows[i].known, directed_rows[i].luma_out);
         end
      end
      req_valid <= 1'b0;

      // Random phases: fresh settings, then mostly raster runs around the band
      for (int phase = 0; phase < RandomPhases; phase++) begin
         wait_idle();
         sender_quiet = (phase == QuietPhase) || (phase == PressurePhase);
         receiver_quiet = (phase == QuietPhase);
         if (phase == 0) begin
            write_reg(CSR_SQUARE_WIDTH, 64'd4);
            write_reg(CSR_SQUARE_HEIGHT, 64'd16);
            write_reg(CSR_MARKER_COUNT, 64'd4);
            write_reg(CSR_DATA_COUNT, 64'd5);
            write_reg(CSR_DATA_BITS, 64'd10);
            write_reg(CSR_ENABLED, 64'd1);
            write_reg(CSR_FIRST_COLUMN, 64'd0);
            write_reg(CSR_BOTTOM_GAP, 64'd0);
         end else if (phase == 1) begin
            write_reg(CSR_SQUARE_WIDTH, with_noise(4095, DimWidth));
            write_reg(CSR_SQUARE_HEIGHT, with_noise(4095, DimWidth));
            write_reg(CSR_MARKER_COUNT, with_noise(4095, DimWidth));
            write_reg(CSR_DATA_COUNT, with_noise(64, DataCountWidth));
            write_reg(CSR_DATA_BITS, '1);
            write_reg(CSR_ENABLED, with_noise(1, 1));
            write_reg(CSR_FIRST_COLUMN, with_noise(4095, DimWidth));
            write_reg(CSR_BOTTOM_GAP, with_noise(4095, DimWidth));
         end else if (phase == 2) begin
            write_reg(CSR_SQUARE_WIDTH, with_noise(1, DimWidth));
            write_reg(CSR_SQUARE_HEIGHT, with_noise(1, DimWidth));
            write_reg(CSR_MARKER_COUNT, with_noise(0, DimWidth));
            write_reg(CSR_DATA_COUNT, with_noise(0, DataCountWidth));
            write_reg(CSR_DATA_BITS, '0);
            write_reg(CSR_ENABLED, with_noise(0, 1));
            write_reg(CSR_FIRST_COLUMN, with_noise(0, DimWidth));
            write_reg(CSR_BOTTOM_GAP, with_noise(0, DimWidth));
         end else begin
            case ($urandom_range(3))
               0: begin
                  bits_word = '1;
               end
               1: begin
                  bits_word = '0;
               end
               default: begin
                  bits_word = {$urandom(), $urandom()};
               end
            endcase
            write_reg(CSR_SQUARE_WIDTH, with_noise(pick(1, 12, 0, 4095), DimWidth));
            write_reg(CSR_SQUARE_HEIGHT, with_noise(pick(1, 10, 0, 4095), DimWidth));
            write_reg(CSR_MARKER_COUNT, with_noise(pick(0, 8, 0, 4095), DimWidth));
            write_reg(CSR_DATA_COUNT, with_noise(pick(0, 70, 0, 127), DataCountWidth));
            write_reg(CSR_DATA_BITS, bits_word);
            write_reg(CSR_ENABLED, with_noise(($urandom_range(9) != 0) ? 1 : 0, 1));
            write_reg(CSR_FIRST_COLUMN, with_noise(pick(0, 40, 0, 4095), DimWidth));
            write_reg(CSR_BOTTOM_GAP, with_noise(pick(0, 20, 0, 4095), DimWidth));
         end
         csr_valid <= 1'b0;
         if (phase == PressurePhase) begin
            hold_request = 1'b1;
         end

         // columns spanned by the whole band
         total = int'(mark_cfg.marker_count) +
                 ((mark_cfg.data_count > DataCountMax) ? 64 : int'(mark_cfg.data_count));
         span = total * int'(mark_cfg.square_width);
         if (span > MaxCoord + 100) begin
            span = MaxCoord + 100;
         end
         run_left = 0;
         run_col = 0;
         run_below = 0;
         for (int n = 0; n < PixelsPerPhase; n++) begin
            if ($urandom_range(3) == 0) begin
               send_pixel(8'($urandom()), 12'($urandom()), 12'($urandom()), 1'b0, 8'h00);
            end else begin
               if (run_left == 0) begin
                  run_left = int'($urandom_range(40, 1));
                  run_col = clamp_coord(int'(mark_cfg.first_column) +
                                        int'($urandom_range(span + 6, 0)) - 3);
                  run_below = clamp_coord(int'(mark_cfg.bottom_gap) - 1 +
                                          int'($urandom_range(
                                             (mark_cfg.square_height > 12 ? 12 :
                                              int'(mark_cfg.square_height)) + 2, 0)));
               end
               col = run_col;
               below = run_below;
               send_pixel(8'($urandom()), 12'(col), 12'(below), 1'b0, 8'h00);
               run_left--;
               run_col++;
               if (run_col > MaxCoord) begin
                  run_left = 0;
               end
            end
         end
         req_valid <= 1'b0;
         sender_quiet = 1'b0;
         receiver_quiet = 1'b0;
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   // Receiver stall: random, plus one long hold that fills the pipeline
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HoldCycles) @(posedge clock);
            hold_done = 1'b1;
         end
         rsp_stall <= !receiver_quiet && ($urandom_range(99) < IdlePercent);
      end
   end

   // Result check against the oldest expected word
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (luma_expect_q.size() == 0) begin
            $display("%0t: result word with nothing expected, actual luma %0d",
                     $time, rsp_luma_out);
            mismatch_count++;
         end else begin
            if (rsp_luma_out !== luma_expect_q[0]) begin
               $display("%0t: luma_out expected %0d, actual %0d",
                        $time, luma_expect_q[0], rsp_luma_out);
               mismatch_count++;
            end
            void'(luma_expect_q.pop_front());
         end
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= WatchdogLimit) begin
         $display("%0t: no word moved for %0d cycles", $time, idle_cycles);
         $display("Mismatches found");
         $finish;
      end
   end

endmodule

`default_nettype wire
